@@ src/tick_history_nearest_lookup_top_defines.svh @@
// Assertion macros used by the checker file of the lookup block.
`ifndef TICK_HISTORY_NEAREST_LOOKUP_TOP_DEFINES_SVH
`define TICK_HISTORY_NEAREST_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define THNL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, off while reset is asserted.
`define THNL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

@@ src/thnl_pkg.sv @@
// Shared constants, types and codes of the tick history lookup block.
package thnl_pkg;

  localparam int HIST_DEPTH  = 64;
  localparam int NUM_PLAYERS = 8;
  localparam int SLOT_W      = $clog2(HIST_DEPTH);
  localparam int FILL_W      = $clog2(HIST_DEPTH + 1);
  localparam int CNT_W       = $clog2(NUM_PLAYERS);
  localparam int SNAP_DEPTH  = HIST_DEPTH * NUM_PLAYERS;
  localparam int SNAP_AW     = $clog2(SNAP_DEPTH);
  localparam int PLY_W       = 3;
  localparam int WORD_W      = 32;
  localparam int ENTRY_W     = 3 * WORD_W + 1;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMMIT,
    ST_SCAN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic              alive;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } tick_ram_req_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [SNAP_AW-1:0] addr;
  } snap_ram_req_t;

  typedef struct packed {
    logic              valid;
    logic              found;
    logic [PLY_W-1:0]  player;
    logic              last;
    logic [WORD_W-1:0] chosen_tick;
    logic [WORD_W-1:0] newest_tick;
    logic [WORD_W-1:0] oldest_tick;
  } result_t;

endpackage

@@ src/tick_history_nearest_lookup_top.sv @@
// Top level of the snapshot history ring with nearest-tick rewind lookup.
//
// Usage: drive a request on op_i, tick_i and the entry fields and raise start;
// the request is taken at a rising edge with start high and busy low.
// A push (op 0) writes one player entry into the staging buffer in that cycle.
// A push with last_entry_i set then commits the staged entries as the newest
// snapshot while busy stays high, one player entry per cycle, limited
// by the single write port of the snapshot memory.
// A query (op 1) walks the tick memory from newest to oldest, one read per
// cycle through a three-stage read / difference / compare pipe, then reads the
// 8 player entries of the chosen snapshot, one per cycle. The 8 results, one
// per player, appear back to back marked by result_valid_o, last_result_o on
// the final one. An empty ring gives one not-found result the cycle after.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset empties the ring; memory contents are left as they are.
module tick_history_nearest_lookup_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [31:0] tick_i,
  input  logic [2:0]  player_index_i,
  input  logic [31:0] pos_x_i,
  input  logic [31:0] pos_y_i,
  input  logic [31:0] pos_z_i,
  input  logic        alive_i,
  input  logic        last_entry_i,
  output logic        result_valid_o,
  output logic        found_o,
  output logic [2:0]  out_player_o,
  output logic [31:0] out_pos_x_o,
  output logic [31:0] out_pos_y_o,
  output logic [31:0] out_pos_z_o,
  output logic        out_alive_o,
  output logic [31:0] chosen_tick_o,
  output logic [31:0] newest_tick_o,
  output logic [31:0] oldest_tick_o,
  output logic        last_result_o
);

  thnl_pkg::entry_t              push_entry, stage_entry, snap_entry;
  logic [thnl_pkg::CNT_W-1:0]    stage_idx;
  thnl_pkg::tick_ram_req_t       tick_req;
  thnl_pkg::snap_ram_req_t       snap_req;
  thnl_pkg::result_t             result;
  logic [thnl_pkg::WORD_W-1:0]   tick_rdata;
  logic [thnl_pkg::ENTRY_W-1:0]  snap_rdata;
  logic                          push_wr;

  assign push_entry = '{x: pos_x_i, y: pos_y_i, z: pos_z_i, alive: alive_i};
  assign push_wr    = start && !busy && (thnl_pkg::op_e'(op_i) == thnl_pkg::OP_PUSH);

  thnl_stage u_stage (
    .clk_i      (clk_i),
    .wr_i       (push_wr),
    .wr_idx_i   (player_index_i),
    .wr_entry_i (push_entry),
    .rd_idx_i   (stage_idx),
    .rd_entry_o (stage_entry)
  );

  thnl_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .op_i         (op_i),
    .tick_i       (tick_i),
    .last_entry_i (last_entry_i),
    .tick_rdata_i (tick_rdata),
    .busy         (busy),
    .stage_idx_o  (stage_idx),
    .tick_req_o   (tick_req),
    .snap_req_o   (snap_req),
    .result_o     (result)
  );

  thnl_ram #(
    .WIDTH (thnl_pkg::WORD_W),
    .DEPTH (thnl_pkg::HIST_DEPTH)
  ) u_tick_ram (
    .clk_i   (clk_i),
    .we_i    (tick_req.we),
    .re_i    (tick_req.re),
    .addr_i  (tick_req.addr),
    .wdata_i (tick_req.wdata),
    .rdata_o (tick_rdata)
  );

  thnl_ram #(
    .WIDTH (thnl_pkg::ENTRY_W),
    .DEPTH (thnl_pkg::SNAP_DEPTH)
  ) u_snap_ram (
    .clk_i   (clk_i),
    .we_i    (snap_req.we),
    .re_i    (snap_req.re),
    .addr_i  (snap_req.addr),
    .wdata_i (stage_entry),
    .rdata_o (snap_rdata)
  );

  // zero the entry fields of a not-found result
  assign snap_entry = result.found ? thnl_pkg::entry_t'(snap_rdata) : '0;

  assign result_valid_o = result.valid;
  assign found_o        = result.found;
  assign out_player_o   = result.player;
  assign out_pos_x_o    = snap_entry.x;
  assign out_pos_y_o    = snap_entry.y;
  assign out_pos_z_o    = snap_entry.z;
  assign out_alive_o    = snap_entry.alive;
  assign chosen_tick_o  = result.chosen_tick;
  assign newest_tick_o  = result.newest_tick;
  assign oldest_tick_o  = result.oldest_tick;
  assign last_result_o  = result.last;

endmodule

@@ src/thnl_ram.sv @@
// Generic single-port synchronous RAM with registered read data.
module thnl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/thnl_stage.sv @@
// Staging buffer: one pending entry per player, read back during commit.
module thnl_stage (
  input  logic                         clk_i,
  input  logic                         wr_i,
  input  logic [thnl_pkg::PLY_W-1:0]   wr_idx_i,
  input  thnl_pkg::entry_t             wr_entry_i,
  input  logic [thnl_pkg::CNT_W-1:0]   rd_idx_i,
  output thnl_pkg::entry_t             rd_entry_o
);

  thnl_pkg::entry_t stage_q [thnl_pkg::NUM_PLAYERS];
  logic             in_range;

  // drop pushes aimed past the last player slot
  assign in_range = 32'(wr_idx_i) < 32'(thnl_pkg::NUM_PLAYERS);

  always_ff @(posedge clk_i) begin
    if (wr_i && in_range) begin
      stage_q[thnl_pkg::CNT_W'(wr_idx_i)] <= wr_entry_i;
    end
  end

  assign rd_entry_o = stage_q[rd_idx_i];

endmodule

@@ src/thnl_ctrl.sv @@
// Sequencer: commit, nearest-tick scan over the tick memory, and result emission.
module thnl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  logic                          op_i,
  input  logic [thnl_pkg::WORD_W-1:0]   tick_i,
  input  logic                          last_entry_i,
  input  logic [thnl_pkg::WORD_W-1:0]   tick_rdata_i,
  output logic                          busy,
  output logic [thnl_pkg::CNT_W-1:0]    stage_idx_o,
  output thnl_pkg::tick_ram_req_t       tick_req_o,
  output thnl_pkg::snap_ram_req_t       snap_req_o,
  output thnl_pkg::result_t             result_o
);

  localparam logic [thnl_pkg::CNT_W-1:0]  CntLast  = thnl_pkg::CNT_W'(thnl_pkg::NUM_PLAYERS - 1);
  localparam logic [thnl_pkg::SLOT_W-1:0] SlotLast = thnl_pkg::SLOT_W'(thnl_pkg::HIST_DEPTH - 1);
  localparam logic [thnl_pkg::FILL_W-1:0] FillMax  = thnl_pkg::FILL_W'(thnl_pkg::HIST_DEPTH);

  thnl_pkg::state_e state_q, state_d;

  logic [thnl_pkg::CNT_W-1:0]  cnt_q;
  logic [thnl_pkg::FILL_W-1:0] scan_cnt_q;
  logic [thnl_pkg::SLOT_W-1:0] rd_slot_q;
  logic [thnl_pkg::SLOT_W-1:0] newest_q;
  logic [thnl_pkg::FILL_W-1:0] filled_q;
  logic [thnl_pkg::WORD_W-1:0] req_tick_q;

  logic                        rv_q, rfirst_q;
  logic [thnl_pkg::SLOT_W-1:0] rslot_q;
  logic                        dv_q, dfirst_q;
  logic [thnl_pkg::SLOT_W-1:0] dslot_q;
  logic [thnl_pkg::WORD_W-1:0] dtick_q, dif_q;

  logic [thnl_pkg::WORD_W-1:0] best_dif_q, best_tick_q, newest_tick_q, oldest_tick_q;
  logic [thnl_pkg::SLOT_W-1:0] best_slot_q;

  logic                        out_v_q, out_found_q, out_last_q;
  logic [thnl_pkg::PLY_W-1:0]  out_player_q;

  logic                        accept, is_push, is_query, issue, scan_done, cnt_end, take_best;
  logic [thnl_pkg::WORD_W-1:0] abs_dif;

  function automatic logic [thnl_pkg::SNAP_AW-1:0] snap_addr(
    input logic [thnl_pkg::SLOT_W-1:0] slot,
    input logic [thnl_pkg::CNT_W-1:0]  player
  );
    snap_addr = thnl_pkg::SNAP_AW'(slot) * thnl_pkg::SNAP_AW'(thnl_pkg::NUM_PLAYERS)
              + thnl_pkg::SNAP_AW'(player);
  endfunction

  assign busy      = (state_q != thnl_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign is_push   = (thnl_pkg::op_e'(op_i) == thnl_pkg::OP_PUSH);
  assign is_query  = (thnl_pkg::op_e'(op_i) == thnl_pkg::OP_QUERY);
  assign issue     = (state_q == thnl_pkg::ST_SCAN) && (scan_cnt_q < filled_q);
  assign scan_done = (scan_cnt_q == filled_q) && !rv_q && !dv_q;
  assign cnt_end   = (cnt_q == CntLast);
  assign abs_dif   = (tick_rdata_i > req_tick_q) ? tick_rdata_i - req_tick_q
                                                 : req_tick_q - tick_rdata_i;
  // strict compare keeps the newer snapshot on a tie
  assign take_best = dfirst_q || (dif_q < best_dif_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      thnl_pkg::ST_IDLE: begin
        if (accept && is_push && last_entry_i) begin
          state_d = thnl_pkg::ST_COMMIT;
        end else if (accept && is_query && (filled_q != '0)) begin
          state_d = thnl_pkg::ST_SCAN;
        end
      end
      thnl_pkg::ST_COMMIT: begin
        if (cnt_end) state_d = thnl_pkg::ST_IDLE;
      end
      thnl_pkg::ST_SCAN: begin
        if (scan_done) state_d = thnl_pkg::ST_EMIT;
      end
      thnl_pkg::ST_EMIT: begin
        if (cnt_end) state_d = thnl_pkg::ST_IDLE;
      end
      default: state_d = thnl_pkg::ST_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    tick_req_o  = '0;
    snap_req_o  = '0;
    stage_idx_o = cnt_q;
    unique case (state_q)
      thnl_pkg::ST_COMMIT: begin
        snap_req_o.we    = 1'b1;
        snap_req_o.addr  = snap_addr(newest_q, cnt_q);
        tick_req_o.we    = (cnt_q == '0);
        tick_req_o.addr  = newest_q;
        tick_req_o.wdata = req_tick_q;
      end
      thnl_pkg::ST_SCAN: begin
        tick_req_o.re   = issue;
        tick_req_o.addr = rd_slot_q;
      end
      thnl_pkg::ST_EMIT: begin
        snap_req_o.re   = 1'b1;
        snap_req_o.addr = snap_addr(best_slot_q, cnt_q);
      end
      default: begin
        tick_req_o = '0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= thnl_pkg::ST_IDLE;
      cnt_q        <= '0;
      scan_cnt_q   <= '0;
      rd_slot_q    <= '0;
      newest_q     <= '0;
      filled_q     <= '0;
      rv_q         <= 1'b0;
      dv_q         <= 1'b0;
      out_v_q      <= 1'b0;
      out_found_q  <= 1'b0;
      out_last_q   <= 1'b0;
      out_player_q <= '0;
    end else begin
      state_q <= state_d;
      rv_q    <= issue;
      dv_q    <= rv_q;
      out_v_q <= 1'b0;
      if (accept) begin
        cnt_q      <= '0;
        scan_cnt_q <= '0;
        rd_slot_q  <= newest_q;
        if (is_push && last_entry_i) begin
          newest_q <= (newest_q == SlotLast) ? '0 : newest_q + 1'b1;
          if (filled_q != FillMax) filled_q <= filled_q + 1'b1;
        end
        if (is_query && (filled_q == '0)) begin
          out_v_q      <= 1'b1;
          out_found_q  <= 1'b0;
          out_last_q   <= 1'b1;
          out_player_q <= '0;
        end
      end
      if (state_q == thnl_pkg::ST_COMMIT) begin
        cnt_q <= cnt_end ? '0 : cnt_q + 1'b1;
      end
      if (issue) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
        rd_slot_q  <= (rd_slot_q == '0) ? SlotLast : rd_slot_q - 1'b1;
      end
      if (state_q == thnl_pkg::ST_EMIT) begin
        cnt_q        <= cnt_end ? '0 : cnt_q + 1'b1;
        out_v_q      <= 1'b1;
        out_found_q  <= 1'b1;
        out_last_q   <= cnt_end;
        out_player_q <= thnl_pkg::PLY_W'(cnt_q);
      end
    end
  end

  // scan datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_tick_q <= tick_i;
    end
    rfirst_q <= (scan_cnt_q == '0);
    rslot_q  <= rd_slot_q;
    if (rv_q) begin
      dfirst_q <= rfirst_q;
      dslot_q  <= rslot_q;
      dtick_q  <= tick_rdata_i;
      dif_q    <= abs_dif;
    end
    if (dv_q) begin
      if (take_best) begin
        best_dif_q  <= dif_q;
        best_slot_q <= dslot_q;
        best_tick_q <= dtick_q;
      end
      if (dfirst_q) newest_tick_q <= dtick_q;
      // the final read of a scan is the oldest slot
      oldest_tick_q <= dtick_q;
    end
  end

  always_comb begin
    result_o.valid       = out_v_q;
    result_o.found       = out_found_q;
    result_o.player      = out_player_q;
    result_o.last        = out_last_q;
    result_o.chosen_tick = out_found_q ? best_tick_q : '0;
    result_o.newest_tick = out_found_q ? newest_tick_q : '0;
    result_o.oldest_tick = out_found_q ? oldest_tick_q : '0;
  end

endmodule

@@ src/thnl_checker.sv @@
// Port-level checker of the lookup block, bound to the top level.
`include "tick_history_nearest_lookup_top_defines.svh"

module thnl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        result_valid_o,
  input logic        found_o,
  input logic [2:0]  out_player_o,
  input logic [31:0] chosen_tick_o,
  input logic        last_result_o
);

  `THNL_ASSERT_NOW(a_notfound_single, clk_i, rst_ni, result_valid_o && !found_o, last_result_o && (out_player_o == 3'd0) && (chosen_tick_o == 32'd0))
  `THNL_ASSERT_NEXT(a_burst_unbroken, clk_i, rst_ni, result_valid_o && !last_result_o, result_valid_o && found_o)
  `THNL_ASSERT_NEXT(a_player_steps, clk_i, rst_ni, result_valid_o && !last_result_o, out_player_o == $past(out_player_o) + 3'd1)
  `THNL_ASSERT_NOW(a_busy_in_burst, clk_i, rst_ni, result_valid_o && !last_result_o, busy)

endmodule

bind tick_history_nearest_lookup_top thnl_checker u_thnl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .found_o        (found_o),
  .out_player_o   (out_player_o),
  .chosen_tick_o  (chosen_tick_o),
  .last_result_o  (last_result_o)
);

@@ verif/tb.sv @@
// Self-checking testbench for the snapshot history ring with nearest-tick rewind lookup.
`timescale 1ns / 100ps

module tb;

  localparam int WORD_W      = thnl_pkg::WORD_W;
  localparam int PLY_W       = thnl_pkg::PLY_W;
  localparam int SLOT_W      = thnl_pkg::SLOT_W;
  localparam int HIST_DEPTH  = thnl_pkg::HIST_DEPTH;
  localparam int NUM_PLAYERS = thnl_pkg::NUM_PLAYERS;

  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 100;

  typedef struct {
    thnl_pkg::op_e     op;
    logic [WORD_W-1:0] tick;
    logic [PLY_W-1:0]  player;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic              alive;
    logic              last;
    int unsigned       gap;
    bit                drain;
  } lookup_req_t;

  typedef struct packed {
    logic              found;
    logic [PLY_W-1:0]  player;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
    logic              alive;
    logic [WORD_W-1:0] chosen;
    logic [WORD_W-1:0] newest;
    logic [WORD_W-1:0] oldest;
    logic              last;
  } rewind_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        op_i = 1'b0;
  logic [31:0] tick_i = '0;
  logic [2:0]  player_index_i = '0;
  logic [31:0] pos_x_i = '0;
  logic [31:0] pos_y_i = '0;
  logic [31:0] pos_z_i = '0;
  logic        alive_i = 1'b0;
  logic        last_entry_i = 1'b0;
  logic        result_valid_o;
  logic        found_o;
  logic [2:0]  out_player_o;
  logic [31:0] out_pos_x_o;
  logic [31:0] out_pos_y_o;
  logic [31:0] out_pos_z_o;
  logic        out_alive_o;
  logic [31:0] chosen_tick_o;
  logic [31:0] newest_tick_o;
  logic [31:0] oldest_tick_o;
  logic        last_result_o;

  tick_history_nearest_lookup_top dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Predicted ring contents and staging buffer
  logic [WORD_W-1:0] hist_tick [HIST_DEPTH];
  thnl_pkg::entry_t  hist_entry [HIST_DEPTH][NUM_PLAYERS];
  thnl_pkg::entry_t  staged [NUM_PLAYERS];
  logic [SLOT_W-1:0] head_slot = '0;
  int unsigned       fill_cnt = 0;

  lookup_req_t    request_q [$];
  rewind_result_t rewind_expect_q [$];
  lookup_req_t    cur_req;
  int unsigned    gap_cnt = 0;
  int unsigned    n_fail = 0;
  int unsigned    quiet_cycles = 0;

  // Generation-side bookkeeping
  logic [WORD_W-1:0] gen_ticks [$];
  int unsigned       n_gen = 0;
  int unsigned       n_gen_commits = 0;
  bit                hold_next = 1'b0;

  task automatic apply_request(input lookup_req_t rq);
    rewind_result_t    res;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] best_slot;
    logic [SLOT_W-1:0] oldest_slot;
    logic [WORD_W-1:0] t;
    logic [WORD_W-1:0] dif;
    logic [WORD_W-1:0] best_dif;
    if (rq.op == thnl_pkg::OP_PUSH) begin
      staged[rq.player] = '{x: rq.x, y: rq.y, z: rq.z, alive: rq.alive};
      if (rq.last) begin
        head_slot = head_slot + 1'b1;
        hist_tick[head_slot] = rq.tick;
        for (int p = 0; p < NUM_PLAYERS; p++) hist_entry[head_slot][p] = staged[p];
        if (fill_cnt < HIST_DEPTH) fill_cnt++;
      end
    end else if (fill_cnt == 0) begin
      res = '0;
      res.last = 1'b1;
      rewind_expect_q.push_back(res);
    end else begin
      best_slot = head_slot;
      best_dif = '0;
      // Walk newest to oldest; a strictly smaller distance is needed to move off the newer one
      for (int i = 0; i < fill_cnt; i++) begin
        slot = head_slot - SLOT_W'(i);
        t = hist_tick[slot];
        dif = (t > rq.tick) ? t - rq.tick : rq.tick - t;
        if (i == 0 || dif < best_dif) begin
          best_dif = dif;
          best_slot = slot;
        end
      end
      oldest_slot = head_slot + 1'b1 - SLOT_W'(fill_cnt);
      for (int p = 0; p < NUM_PLAYERS; p++) begin
        res.found = 1'b1;
        res.player = PLY_W'(p);
        res.x = hist_entry[best_slot][p].x;
        res.y = hist_entry[best_slot][p].y;
        res.z = hist_entry[best_slot][p].z;
        res.alive = hist_entry[best_slot][p].alive;
        res.chosen = hist_tick[best_slot];
        res.newest = hist_tick[head_slot];
        res.oldest = hist_tick[oldest_slot];
        res.last = (p == NUM_PLAYERS - 1);
        rewind_expect_q.push_back(res);
      end
    end
  endtask

  function automatic int unsigned draw_gap();
    // Every third stretch of 20 requests goes back to back
    if ((n_gen / 20) % 3 == 2) return 0;
    return $urandom_range(0, 9);
  endfunction

  task automatic add_push(input logic [PLY_W-1:0] player, input logic [WORD_W-1:0] tick,
                          input logic [WORD_W-1:0] x, input logic [WORD_W-1:0] y,
                          input logic [WORD_W-1:0] z, input logic alive, input logic last);
    lookup_req_t rq;
    rq = '{op: thnl_pkg::OP_PUSH, tick: tick, player: player, x: x, y: y, z: z,
           alive: alive, last: last, gap: draw_gap(), drain: hold_next};
    request_q.push_back(rq);
    hold_next = 1'b0;
    n_gen++;
    if (last) begin
      n_gen_commits++;
      gen_ticks.push_back(tick);
      if (gen_ticks.size() > HIST_DEPTH) void'(gen_ticks.pop_front());
    end
  endtask

  task automatic add_query(input logic [WORD_W-1:0] tick);
    lookup_req_t rq;
    // Fill the fields a query ignores with noise
    rq = '{op: thnl_pkg::OP_QUERY, tick: tick, player: PLY_W'($urandom()), x: $urandom(),
           y: $urandom(), z: $urandom(), alive: 1'($urandom()), last: 1'($urandom()),
           gap: draw_gap(), drain: hold_next};
    request_q.push_back(rq);
    hold_next = 1'b0;
    n_gen++;
  endtask

  // Driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) apply_request(cur_req);
      if (!start || !busy) begin
        if (request_q.size() == 0) begin
          start <= 1'b0;
        end else if (gap_cnt < request_q[0].gap) begin
          gap_cnt++;
          start <= 1'b0;
        end else if (request_q[0].drain && rewind_expect_q.size() != 0) begin
          start <= 1'b0;
        end else begin
          cur_req = request_q.pop_front();
          gap_cnt = 0;
          start <= 1'b1;
          op_i <= cur_req.op;
          tick_i <= cur_req.tick;
          player_index_i <= cur_req.player;
          pos_x_i <= cur_req.x;
          pos_y_i <= cur_req.y;
          pos_z_i <= cur_req.z;
          alive_i <= cur_req.alive;
          last_entry_i <= cur_req.last;
        end
      end
    end
  end

  // Monitor and watchdog
  always @(posedge clk_i) begin
    rewind_result_t got;
    rewind_result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        got = {found_o, out_player_o, out_pos_x_o, out_pos_y_o, out_pos_z_o, out_alive_o,
               chosen_tick_o, newest_tick_o, oldest_tick_o, last_result_o};
        if (rewind_expect_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10) $display("unexpected result: player=%0d", out_player_o);
        end else begin
          want = rewind_expect_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  exp found=%b ply=%0d x=%h y=%h z=%h alive=%b", want.found,
                       want.player, want.x, want.y, want.z, want.alive);
              $display("      chosen=%h newest=%h oldest=%h last=%b", want.chosen,
                       want.newest, want.oldest, want.last);
              $display("  got found=%b ply=%0d x=%h y=%h z=%h alive=%b", got.found,
                       got.player, got.x, got.y, got.z, got.alive);
              $display("      chosen=%h newest=%h oldest=%h last=%b", got.chosen,
                       got.newest, got.oldest, got.last);
            end
          end
        end
      end
      if ((start && !busy) || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("[FAIL] regression broken");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned       extra;
    int unsigned       pick;
    logic [WORD_W-1:0] base_tick;
    logic [WORD_W-1:0] qa;
    logic [WORD_W-1:0] qb;

    // Empty ring
    add_query(32'h1234_5678);
    // Stage every player with extreme words, commit at tick 0
    for (int p = 0; p < NUM_PLAYERS; p++) begin
      add_push(PLY_W'(p), 32'd0, p[0] ? '1 : '0, p[0] ? '0 : '1, p[1] ? '1 : '0,
               p[0], p == NUM_PLAYERS - 1);
    end
    // Single snapshot, largest possible distance
    add_query(32'hFFFF_FFFF);
    hold_next = 1'b1;
    add_push(3'd7, 32'hFFFF_FFFF, '1, '1, '1, 1'b1, 1'b1);
    add_query(32'h7FFF_FFFF);
    add_query(32'h8000_0000);
    add_push(3'd3, 32'd100, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0001, 1'b0, 1'b1);
    add_push(3'd4, 32'd200, 32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF, 1'b1, 1'b1);
    // Equal distance to 100 and 200: the newer wins
    add_query(32'd150);
    add_query(32'd0);
    // Same tick committed twice: the newer wins
    add_push(3'd5, 32'd200, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h3C3C_3C3C, 1'b0, 1'b1);
    add_query(32'd200);

    base_tick = 32'd200;
    while (n_gen < 170 || n_gen_commits < 80) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) hold_next = 1'b1;
      if (pick < 65) begin
        extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0;
        repeat (extra) begin
          add_push(PLY_W'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                   1'($urandom()), 1'b0);
        end
        if ($urandom_range(0, 9) == 0) base_tick = $urandom();
        else base_tick = base_tick + $urandom_range(0, 4);
        add_push(PLY_W'($urandom()), base_tick, $urandom(), $urandom(), $urandom(),
                 1'($urandom()), 1'b1);
      end else if (pick < 95) begin
        pick = $urandom_range(0, 9);
        qa = gen_ticks[$urandom_range(0, gen_ticks.size() - 1)];
        qb = gen_ticks[$urandom_range(0, gen_ticks.size() - 1)];
        unique case (pick)
          0, 1, 2, 3: add_query(qa + $urandom_range(0, 4) - 2);
          4, 5:       add_query(WORD_W'(({1'b0, qa} + {1'b0, qb}) >> 1));
          6, 7:       add_query($urandom());
          8:          add_query('0);
          default:    add_query('1);
        endcase
      end else begin
        // Stage without committing
        add_push(PLY_W'($urandom()), $urandom(), $urandom(), $urandom(), $urandom(),
                 1'($urandom()), 1'b0);
      end
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (request_q.size() != 0 || start || busy || rewind_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    n_fail += rewind_expect_q.size();
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
